>>> design/bar_pkg.sv
// Shared types and constants of the bias auto-ranging resistance unit.
package bar_pkg;

  // Field widths
  localparam int unsigned CodeW  = 12;  // ADC code
  localparam int unsigned ProdW  = 24;  // code * volt step
  localparam int unsigned LimW   = 21;  // limits, reported voltage and resistance
  localparam int unsigned IdxW   = 4;   // bias index
  localparam int unsigned UaW    = 7;   // bias current in uA
  localparam int unsigned TryW   = 7;   // try counter
  localparam int unsigned CfgIdxW = 3;

  // Iterations of the shared unit
  localparam int unsigned MulSteps = CodeW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned CntW     = 5;

  // Register reset values
  localparam logic [LimW-1:0]  LowLimitRst  = 21'd300000;
  localparam logic [LimW-1:0]  HighLimitRst = 21'd1250000;
  localparam logic [CodeW-1:0] VoltStepRst  = 12'd342;
  localparam logic [IdxW-1:0]  StartIdxRst  = 4'd6;
  localparam logic [TryW-1:0]  MaxTriesRst  = 7'd16;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_LIMIT  = 3'd0,
    REG_HIGH_LIMIT = 3'd1,
    REG_VOLT_STEP  = 3'd2,
    REG_START_IDX  = 3'd3,
    REG_MAX_TRIES  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LimW-1:0]  low_limit_uv;
    logic [LimW-1:0]  high_limit_uv;
    logic [CodeW-1:0] volt_step_uv;
    logic [IdxW-1:0]  start_index;
    logic [TryW-1:0]  max_tries;
  } cfg_t;

  // Shared arithmetic unit operations
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [ProdW-1:0]  a;  // multiplicand or dividend
    logic [CodeW-1:0]  b;  // multiplier or divisor
  } unit_cmd_t;

  typedef struct packed {
    logic              done;
    logic [ProdW-1:0]  result;
  } unit_rsp_t;

endpackage

>>> design/bar_cfg.sv
// Configuration registers of the bias auto-ranging resistance unit.
module bar_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [bar_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bar_pkg::LimW-1:0]    cfg_data,
  output bar_pkg::cfg_t               cfg
);

  // Register file, written one register per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit_uv  <= bar_pkg::LowLimitRst;
      cfg.high_limit_uv <= bar_pkg::HighLimitRst;
      cfg.volt_step_uv  <= bar_pkg::VoltStepRst;
      cfg.start_index   <= bar_pkg::StartIdxRst;
      cfg.max_tries     <= bar_pkg::MaxTriesRst;
    end else if (cfg_write) begin
      case (cfg_index)
        bar_pkg::REG_LOW_LIMIT:  cfg.low_limit_uv  <= cfg_data;
        bar_pkg::REG_HIGH_LIMIT: cfg.high_limit_uv <= cfg_data;
        bar_pkg::REG_VOLT_STEP:  cfg.volt_step_uv  <= cfg_data[bar_pkg::CodeW-1:0];
        bar_pkg::REG_START_IDX:  cfg.start_index   <= cfg_data[bar_pkg::IdxW-1:0];
        bar_pkg::REG_MAX_TRIES:  cfg.max_tries     <= cfg_data[bar_pkg::TryW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/bar_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
module bar_muldiv (
  input  logic                clk,
  input  logic                rst,
  input  bar_pkg::unit_cmd_t  cmd,
  output bar_pkg::unit_rsp_t  rsp
);

  localparam int unsigned PW = bar_pkg::ProdW;
  localparam int unsigned CW = bar_pkg::CodeW;
  localparam int unsigned UW = bar_pkg::UaW;
  localparam logic [bar_pkg::CntW-1:0] MulLast = bar_pkg::CntW'(bar_pkg::MulSteps - 1);
  localparam logic [bar_pkg::CntW-1:0] DivLast = bar_pkg::CntW'(bar_pkg::DivSteps - 1);

  logic                     running;
  logic                     done;
  bar_pkg::op_t             op;
  logic [bar_pkg::CntW-1:0] cnt;
  logic [PW-1:0]            acc;   // product, or dividend/quotient
  logic [PW-1:0]            mcand; // shifted multiplicand
  logic [CW-1:0]            mplr;  // multiplier bits, or divisor
  logic [UW-1:0]            rem;

  logic [UW:0]   rem_shift;
  logic [PW-1:0] add_a;
  logic [PW-1:0] add_b;
  logic          add_cin;
  logic [PW:0]   sum;
  logic          last;

  // Operand select for the one adder
  always_comb begin
    rem_shift = {rem, acc[PW-1]};
    if (op == bar_pkg::OP_MUL) begin
      add_a   = acc;
      add_b   = mcand;
      add_cin = 1'b0;
    end else begin
      add_a   = {{(PW-UW-1){1'b0}}, rem_shift};
      add_b   = ~{{(PW-UW){1'b0}}, mplr[UW-1:0]};
      add_cin = 1'b1;
    end
    sum  = {1'b0, add_a} + {1'b0, add_b} + {{PW{1'b0}}, add_cin};
    last = (op == bar_pkg::OP_MUL) ? (cnt == MulLast) : (cnt == DivLast);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath, one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= cmd.op;
      if (cmd.op == bar_pkg::OP_MUL) begin
        acc   <= '0;
        mcand <= cmd.a;
      end else begin
        acc   <= cmd.a;
        mcand <= '0;
      end
      mplr <= cmd.b;
      rem  <= '0;
    end else if (running) begin
      if (op == bar_pkg::OP_MUL) begin
        if (mplr[0]) acc <= sum[PW-1:0];
        mcand <= {mcand[PW-2:0], 1'b0};
        mplr  <= {1'b0, mplr[CW-1:1]};
      end else if (sum[PW]) begin
        rem <= sum[UW-1:0];
        acc <= {acc[PW-2:0], 1'b1};
      end else begin
        rem <= rem_shift[UW-1:0];
        acc <= {acc[PW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

>>> design/bias_autorange_resistance_unit.sv
// Bias auto-ranging resistance unit: sequencer, output register and checks.
//
// A start transfer (action 0) selects an ADC input, loads the bias index from
// start_index and, through the output state, raises out_valid with the first
// bias code. Each sample transfer (action 1) forms the 12-bit code, multiplies
// it by volt_step_uv, steps the bias index down or up against the limits, and
// returns either the next bias code or the finished measurement with
// resistance = voltage / (1 + 5*index). All arithmetic runs on one shared
// adder. A sample that continues ranging passes the multiply, evaluate and
// output states, and one that finishes also passes the divide state before the
// output state. in_stall stays high while an item is in work and drops in the
// cycle out_valid rises, so no new item is taken before the last one has
// reached the output registers; while out_stall holds the previous result, the
// sequencer waits in its output state. A sample that arrives with no
// measurement under way is taken and gives no result. Voltage and resistance
// saturate at 2097151. Write configuration only while idle.
module bias_autorange_resistance_unit (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [bar_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bar_pkg::LimW-1:0]    cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [1:0]                  adc_select,
  input  logic [7:0]                  sample_hi,
  input  logic [7:0]                  sample_lo,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [1:0]                  adc_number,
  output logic [bar_pkg::IdxW-1:0]    bias_code,
  output logic [bar_pkg::UaW-1:0]     bias_ua,
  output logic [bar_pkg::LimW-1:0]    voltage_uv,
  output logic [bar_pkg::LimW-1:0]    resistance_ohm,
  output logic                        at_limit
);

  localparam int unsigned PW = bar_pkg::ProdW;
  localparam int unsigned LW = bar_pkg::LimW;
  localparam int unsigned IW = bar_pkg::IdxW;
  localparam int unsigned UW = bar_pkg::UaW;
  localparam int unsigned TW = bar_pkg::TryW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_EVAL = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  bar_pkg::cfg_t      cfg;
  bar_pkg::unit_cmd_t unit_cmd;
  bar_pkg::unit_rsp_t unit_rsp;

  state_t state, state_next;

  // measurement state
  logic          meas_busy;
  logic [IW-1:0] bias_index;
  logic [TW-1:0] tries_used;
  logic [1:0]    selected_adc;
  logic [PW-1:0] volt;

  // pending result
  logic          res_kind;
  logic [IW-1:0] res_code;
  logic [UW-1:0] res_ua;
  logic [LW-1:0] res_volt;
  logic [LW-1:0] res_ohm;
  logic          res_lim;

  logic in_xfer, out_xfer, out_free;
  logic [UW-1:0] cur_ua;
  logic [UW-1:0] start_ua;
  logic below, above, finish, lim_flag;
  logic [IW-1:0] idx_new;
  logic [TW-1:0] tries_inc, tries_lim;
  logic [LW-1:0] volt_sat;

  bar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bar_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .cmd (unit_cmd),
    .rsp (unit_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  // bias current 1 + 5*index
  assign cur_ua   = UW'({bias_index, 2'b00}) + UW'(bias_index) + UW'(1);
  assign start_ua = UW'({cfg.start_index, 2'b00}) + UW'(cfg.start_index) + UW'(1);
  assign volt_sat = (volt[PW-1:LW] != '0) ? {LW{1'b1}} : volt[LW-1:0];

  // Range decision on the measured voltage
  always_comb begin
    below     = volt < PW'(cfg.low_limit_uv);
    above     = volt > PW'(cfg.high_limit_uv);
    tries_inc = (tries_used == {TW{1'b1}}) ? tries_used : tries_used + 1'b1;
    tries_lim = (cfg.max_tries == '0) ? TW'(1) : cfg.max_tries;
    finish    = 1'b0;
    lim_flag  = 1'b0;
    idx_new   = bias_index;
    if (below) begin
      if (bias_index == {IW{1'b1}}) begin
        finish   = 1'b1;
        lim_flag = 1'b1;
      end else begin
        idx_new = bias_index + 1'b1;
      end
    end else if (above) begin
      if (bias_index == '0) begin
        finish   = 1'b1;
        lim_flag = 1'b1;
      end else begin
        idx_new = bias_index - 1'b1;
      end
    end else begin
      finish = 1'b1;
    end
    // out of tries: finish at the last measured index
    if (!finish && tries_inc >= tries_lim) begin
      finish   = 1'b1;
      lim_flag = 1'b1;
      idx_new  = bias_index;
    end
  end

  // Commands to the shared unit
  always_comb begin
    unit_cmd.start = 1'b0;
    unit_cmd.op    = bar_pkg::OP_MUL;
    unit_cmd.a     = PW'({sample_hi, sample_lo[3:0]});
    unit_cmd.b     = cfg.volt_step_uv;
    if (state == S_IDLE) begin
      unit_cmd.start = in_xfer && action && meas_busy;
    end else if (state == S_EVAL) begin
      unit_cmd.start = finish;
      unit_cmd.op    = bar_pkg::OP_DIV;
      unit_cmd.a     = volt;
      unit_cmd.b     = bar_pkg::CodeW'(cur_ua);
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (!action) state_next = S_OUT;
          else if (meas_busy) state_next = S_MUL;
        end
      end
      S_MUL:  if (unit_rsp.done) state_next = S_EVAL;
      S_EVAL: state_next = finish ? S_DIV : S_OUT;
      S_DIV:  if (unit_rsp.done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      meas_busy    <= 1'b0;
      bias_index   <= '0;
      tries_used   <= '0;
      selected_adc <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_xfer && !action) begin
        meas_busy    <= 1'b1;
        selected_adc <= adc_select;
        bias_index   <= cfg.start_index;
        tries_used   <= '0;
      end
      if (state == S_EVAL) begin
        tries_used <= tries_inc;
        bias_index <= idx_new;
        if (finish) meas_busy <= 1'b0;
      end
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_xfer) out_valid <= 1'b0;
    end
  end

  // Result and payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer && !action) begin
      res_kind <= 1'b0;
      res_code <= cfg.start_index;
      res_ua   <= start_ua;
      res_volt <= '0;
      res_ohm  <= '0;
      res_lim  <= 1'b0;
    end
    if (state == S_MUL && unit_rsp.done) volt <= unit_rsp.result;
    if (state == S_EVAL) begin
      res_kind <= finish;
      res_code <= idx_new;
      res_ua   <= cur_ua;
      res_volt <= volt_sat;
      res_ohm  <= '0;
      res_lim  <= lim_flag;
    end
    if (state == S_DIV && unit_rsp.done) begin
      res_ohm <= (unit_rsp.result[PW-1:LW] != '0) ? {LW{1'b1}} : unit_rsp.result[LW-1:0];
    end
    if (state == S_OUT && out_free) begin
      kind           <= res_kind;
      adc_number     <= selected_adc;
      bias_code      <= res_code;
      bias_ua        <= res_ua;
      voltage_uv     <= res_volt;
      resistance_ohm <= res_ohm;
      at_limit       <= res_lim;
    end
  end

`ifndef ASSERT_OFF
  // the shared unit only reports while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    unit_rsp.done |-> (state == S_MUL || state == S_DIV))
    else $error("arithmetic unit done outside MUL/DIV");

  // a bias update never carries a resistance or a limit flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> (resistance_ohm == '0 && !at_limit))
    else $error("bias update with resistance or limit flag");

  // a finished result reports the current of its own bias code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> bias_ua == UW'({bias_code, 2'b00}) + UW'(bias_code) + UW'(1))
    else $error("finished result with inconsistent bias current");

  // the divider runs only on a finishing sample
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !meas_busy)
    else $error("divide while measurement still ranging");
`endif

endmodule
